@@ design/rwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared widths, types, register indexes and the sequencer's control store
// for the random waypoint mobility step core.
// ----------------------------------------------------------------------------
package rwm_pkg;

   // Field and datapath widths
   localparam int CoordBits    = 16;
   localparam int DeltaBits    = CoordBits + 1;
   localparam int SqBits       = 2 * CoordBits + 1;
   localparam int FracBits     = 16;
   localparam int RootBits     = (SqBits + FracBits + 1) / 2;
   localparam int RadBits      = 2 * RootBits;
   localparam int SpeedBits    = 16;
   localparam int StepsBits    = 25;
   localparam int StepsMax     = 33554431;
   localparam int SumBits      = ((RootBits > StepsBits) ? RootBits : StepsBits) + 1;
   localparam int RestBits     = 7;
   localparam int MaxRestSteps = 100;
   localparam int DelayBits    = 24;
   localparam int DataBits     = 32;
   localparam int AddrBits     = 5;
   localparam int CntBits      = $clog2(RootBits);
   localparam int PcBits       = 4;

   // Register reset values
   localparam int ResetMinX       = 5;
   localparam int ResetMaxX       = 995;
   localparam int ResetMinY       = 5;
   localparam int ResetMaxY       = 995;
   localparam int ResetPauseDelay = 1000000;
   localparam int ResetMoveDelay  = 100000;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [SpeedBits-1:0] speed_type;
   typedef logic [RestBits-1:0]  rest_type;
   typedef logic [DelayBits-1:0] delay_type;
   typedef logic [DataBits-1:0]  data_type;
   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [PcBits-1:0]    pc_type;
   typedef logic [CntBits-1:0]   cnt_type;

   typedef enum logic [2:0] {
      REG_MIN_X,
      REG_MAX_X,
      REG_MIN_Y,
      REG_MAX_Y,
      REG_PAUSE_DELAY,
      REG_MOVE_DELAY
   } reg_index_type;

   typedef struct packed {
      coord_type min_x;
      coord_type max_x;
      coord_type min_y;
      coord_type max_y;
      delay_type pause_delay;
      delay_type move_delay;
   } cfg_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STEPS_SET,
      OP_DXY_STEP,
      OP_DXY_SET,
      OP_REST,
      OP_MOVE
   } op_type;

   // Sequencing of the step counter
   typedef enum logic [2:0] {
      BR_NEXT,
      BR_ACCEPT,
      BR_LOOP,
      BR_NOT_LEG,
      BR_ZERO_SPEED,
      BR_JUMP,
      BR_OUT_FREE
   } br_type;

   typedef struct packed {
      op_type  op;
      br_type  br;
      logic    ld_cnt;
      cnt_type cnt;
      pc_type  target;
   } uword_type;

   typedef struct packed {
      logic   en;
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic leg;
      logic zero_speed;
      logic out_free;
   } stat_type;

   localparam pc_type PcWait = pc_type'(0);
   localparam pc_type PcRest = pc_type'(12);
   localparam pc_type PcMove = pc_type'(13);

   // Control store. A leg start with a nonzero speed runs the square root, the step
   // count division and the two delta divisions; a zero speed sets up a rest leg, and
   // a movement tick jumps straight to the final step.
   function automatic uword_type rwm_ucode(input pc_type pc);
      uword_type w;
      w = '{op: OP_NOP, br: BR_JUMP, ld_cnt: 1'b0, cnt: '0, target: PcWait};
      case (pc)
         4'd0: w = '{op: OP_LOAD, br: BR_ACCEPT, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd1: w = '{op: OP_NOP, br: BR_NOT_LEG, ld_cnt: 1'b0, cnt: '0, target: PcMove};
         4'd2: w = '{op: OP_NOP, br: BR_ZERO_SPEED, ld_cnt: 1'b0, cnt: '0, target: PcRest};
         4'd3: w = '{op: OP_SQX, br: BR_NEXT, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd4: w = '{op: OP_SQY, br: BR_NEXT, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd5: w = '{op: OP_SQRT_INIT, br: BR_NEXT, ld_cnt: 1'b1,
                     cnt: cnt_type'(RootBits - 1), target: PcWait};
         4'd6: w = '{op: OP_SQRT_STEP, br: BR_LOOP, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd7: w = '{op: OP_DIV_INIT, br: BR_NEXT, ld_cnt: 1'b1,
                     cnt: cnt_type'(RootBits - 1), target: PcWait};
         4'd8: w = '{op: OP_DIV_STEP, br: BR_LOOP, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd9: w = '{op: OP_STEPS_SET, br: BR_NEXT, ld_cnt: 1'b1,
                     cnt: cnt_type'(CoordBits - 1), target: PcWait};
         4'd10: w = '{op: OP_DXY_STEP, br: BR_LOOP, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd11: w = '{op: OP_DXY_SET, br: BR_JUMP, ld_cnt: 1'b0, cnt: '0, target: PcMove};
         4'd12: w = '{op: OP_REST, br: BR_NEXT, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         4'd13: w = '{op: OP_MOVE, br: BR_OUT_FREE, ld_cnt: 1'b0, cnt: '0, target: PcWait};
         default: w = '{op: OP_NOP, br: BR_JUMP, ld_cnt: 1'b0, cnt: '0, target: PcWait};
      endcase
      return w;
   endfunction

endpackage

@@ design/rwm_csr.sv @@
// ----------------------------------------------------------------------------
// rwm_csr
// Bounds and delay registers behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module rwm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  rwm_pkg::addr_type paddr,
   input  rwm_pkg::data_type pwdata,
   output rwm_pkg::data_type prdata,
   output logic              pready,
   output rwm_pkg::cfg_type  cfg
);
   import rwm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[AddrBits-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_MIN_X:       cfg_in.min_x       = pwdata[CoordBits-1:0];
            REG_MAX_X:       cfg_in.max_x       = pwdata[CoordBits-1:0];
            REG_MIN_Y:       cfg_in.min_y       = pwdata[CoordBits-1:0];
            REG_MAX_Y:       cfg_in.max_y       = pwdata[CoordBits-1:0];
            REG_PAUSE_DELAY: cfg_in.pause_delay = pwdata[DelayBits-1:0];
            REG_MOVE_DELAY:  cfg_in.move_delay  = pwdata[DelayBits-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MIN_X:       prdata = DataBits'(cfg_ff.min_x);
         REG_MAX_X:       prdata = DataBits'(cfg_ff.max_x);
         REG_MIN_Y:       prdata = DataBits'(cfg_ff.min_y);
         REG_MAX_Y:       prdata = DataBits'(cfg_ff.max_y);
         REG_PAUSE_DELAY: prdata = DataBits'(cfg_ff.pause_delay);
         REG_MOVE_DELAY:  prdata = DataBits'(cfg_ff.move_delay);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x       <= coord_type'(ResetMinX);
         cfg_ff.max_x       <= coord_type'(ResetMaxX);
         cfg_ff.min_y       <= coord_type'(ResetMinY);
         cfg_ff.max_y       <= coord_type'(ResetMaxY);
         cfg_ff.pause_delay <= delay_type'(ResetPauseDelay);
         cfg_ff.move_delay  <= delay_type'(ResetMoveDelay);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/rwm_seq.sv @@
// ----------------------------------------------------------------------------
// rwm_seq
// Step counter, iteration counter and control store lookup that drive the datapath
// one control word per cycle, held while awaiting a request or a free output.
// ----------------------------------------------------------------------------
module rwm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rwm_pkg::stat_type stat,
   output rwm_pkg::ctl_type  ctl
);
   import rwm_pkg::*;

   pc_type    pc_ff;
   pc_type    pc_in;
   cnt_type   cnt_ff;
   cnt_type   cnt_in;
   uword_type word;

   assign word      = rwm_ucode(pc_ff);
   assign req_stall = (word.br != BR_ACCEPT);

   always_comb begin
      pc_in   = pc_ff + pc_type'(1);
      cnt_in  = cnt_ff;
      ctl.op  = word.op;
      ctl.en  = 1'b1;
      case (word.br)
         BR_NEXT: begin
            pc_in = pc_ff + pc_type'(1);
         end
         BR_ACCEPT: begin
            ctl.en = req_valid;
            pc_in  = req_valid ? pc_ff + pc_type'(1) : pc_ff;
         end
         BR_LOOP: begin
            if (cnt_ff != '0) begin
               pc_in  = pc_ff;
               cnt_in = cnt_ff - cnt_type'(1);
            end
         end
         BR_NOT_LEG: begin
            if (!stat.leg) begin
               pc_in = word.target;
            end
         end
         BR_ZERO_SPEED: begin
            if (stat.zero_speed) begin
               pc_in = word.target;
            end
         end
         BR_JUMP: begin
            pc_in = word.target;
         end
         BR_OUT_FREE: begin
            // The result is written only once the output register can take it.
            ctl.en = stat.out_free;
            pc_in  = stat.out_free ? word.target : pc_ff;
         end
         default: begin
            pc_in = PcWait;
         end
      endcase
      if (word.ld_cnt) begin
         cnt_in = word.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= PcWait;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ design/rwm_datapath.sv @@
// ----------------------------------------------------------------------------
// rwm_datapath
// Leg state, a shared squarer, shift-subtract square root and dividers, the
// clamping adders and the result register.
// ----------------------------------------------------------------------------
module rwm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rwm_pkg::ctl_type    ctl,
   output rwm_pkg::stat_type   stat,
   input  rwm_pkg::cfg_type    cfg,
   input  rwm_pkg::coord_type  req_cur_x,
   input  rwm_pkg::coord_type  req_cur_y,
   input  rwm_pkg::speed_type  req_rand_speed,
   input  rwm_pkg::coord_type  req_rand_dest_x,
   input  rwm_pkg::coord_type  req_rand_dest_y,
   input  rwm_pkg::rest_type   req_rand_rest_steps,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rwm_pkg::coord_type  rsp_new_x,
   output rwm_pkg::coord_type  rsp_new_y,
   output rwm_pkg::delay_type  rsp_delay,
   output logic                rsp_leg_start
);
   import rwm_pkg::*;

   // Leg state
   logic [StepsBits-1:0] steps_ff,  steps_in;
   logic [DeltaBits-1:0] dx_ff,     dx_in;
   logic [DeltaBits-1:0] dy_ff,     dy_in;

   // Item registers
   coord_type            cur_x_ff,  cur_x_in;
   coord_type            cur_y_ff,  cur_y_in;
   speed_type            speed_ff,  speed_in;
   rest_type             rest_ff,   rest_in;
   coord_type            mag_x_ff,  mag_x_in;
   coord_type            mag_y_ff,  mag_y_in;
   logic                 sign_x_ff, sign_x_in;
   logic                 sign_y_ff, sign_y_in;
   logic                 leg_ff,    leg_in;

   // Arithmetic working registers
   logic [SqBits-1:0]     acc_ff,   acc_in;
   logic [RadBits-1:0]    rad_ff,   rad_in;
   logic [RootBits+1:0]   srem_ff,  srem_in;
   logic [RootBits-1:0]   root_ff,  root_in;
   logic [RootBits-1:0]   q_ff,     q_in;
   logic [SpeedBits-1:0]  drem_ff,  drem_in;
   coord_type             qx_ff,    qx_in;
   coord_type             qy_ff,    qy_in;
   logic [StepsBits-1:0]  remx_ff,  remx_in;
   logic [StepsBits-1:0]  remy_ff,  remy_in;

   // Result register
   logic      rsp_valid_ff, rsp_valid_in;
   coord_type new_x_ff,     new_x_in;
   coord_type new_y_ff,     new_y_in;
   delay_type delay_ff,     delay_in;
   logic      leg_out_ff,   leg_out_in;

   // Combinational helpers
   logic [DeltaBits-1:0]   off_x;
   logic [DeltaBits-1:0]   off_y;
   coord_type              sq_op;
   logic [2*CoordBits-1:0] sq;
   logic [RootBits+3:0]    s_shift;
   logic [RootBits+3:0]    s_trial;
   logic [SpeedBits:0]     d_shift;
   logic [SumBits-1:0]     steps_sum;
   logic [StepsBits:0]     x_shift;
   logic [StepsBits:0]     y_shift;
   logic [StepsBits-1:0]   rest_ext;
   logic signed [CoordBits+1:0] sum_x, sum_y, clip_x, clip_y;
   logic signed [CoordBits+1:0] lo_x, hi_x, lo_y, hi_y;
   logic      do_op;
   logic      out_free;

   assign do_op    = ctl.en;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign stat.leg        = leg_ff;
   assign stat.zero_speed = (speed_ff == '0);
   assign stat.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_x     = new_x_ff;
   assign rsp_new_y     = new_y_ff;
   assign rsp_delay     = delay_ff;
   assign rsp_leg_start = leg_out_ff;

   assign off_x = {1'b0, req_rand_dest_x} - {1'b0, req_cur_x};
   assign off_y = {1'b0, req_rand_dest_y} - {1'b0, req_cur_y};

   // One squarer serves both offsets.
   assign sq_op = (ctl.op == OP_SQY) ? mag_y_ff : mag_x_ff;
   assign sq    = sq_op * sq_op;

   // One result bit of the square root per cycle, two radicand bits at a time.
   assign s_shift = {srem_ff, rad_ff[RadBits-1 -: 2]};
   assign s_trial = (RootBits + 4)'({root_ff, 2'b01});

   assign d_shift   = {drem_ff, q_ff[RootBits-1]};
   assign steps_sum = SumBits'(q_ff) + SumBits'(1);
   assign x_shift   = {remx_ff, qx_ff[CoordBits-1]};
   assign y_shift   = {remy_ff, qy_ff[CoordBits-1]};
   assign rest_ext  = StepsBits'(rest_ff);

   // Position update: limit to the maximum first, then raise to the minimum.
   always_comb begin
      sum_x  = $signed({2'b00, cur_x_ff}) + $signed({dx_ff[DeltaBits-1], dx_ff});
      sum_y  = $signed({2'b00, cur_y_ff}) + $signed({dy_ff[DeltaBits-1], dy_ff});
      lo_x   = $signed({2'b00, cfg.min_x});
      hi_x   = $signed({2'b00, cfg.max_x});
      lo_y   = $signed({2'b00, cfg.min_y});
      hi_y   = $signed({2'b00, cfg.max_y});
      clip_x = (sum_x > hi_x) ? hi_x : sum_x;
      clip_x = (clip_x < lo_x) ? lo_x : clip_x;
      clip_y = (sum_y > hi_y) ? hi_y : sum_y;
      clip_y = (clip_y < lo_y) ? lo_y : clip_y;
   end

   always_comb begin
      steps_in  = steps_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      speed_in  = speed_ff;
      rest_in   = rest_ff;
      mag_x_in  = mag_x_ff;
      mag_y_in  = mag_y_ff;
      sign_x_in = sign_x_ff;
      sign_y_in = sign_y_ff;
      leg_in    = leg_ff;
      acc_in    = acc_ff;
      rad_in    = rad_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      q_in      = q_ff;
      drem_in   = drem_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      remx_in   = remx_ff;
      remy_in   = remy_ff;
      new_x_in  = new_x_ff;
      new_y_in  = new_y_ff;
      delay_in  = delay_ff;
      leg_out_in   = leg_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (do_op) begin
         case (ctl.op)
            OP_LOAD: begin
               cur_x_in  = req_cur_x;
               cur_y_in  = req_cur_y;
               speed_in  = req_rand_speed;
               rest_in   = req_rand_rest_steps;
               sign_x_in = off_x[DeltaBits-1];
               sign_y_in = off_y[DeltaBits-1];
               mag_x_in  = off_x[DeltaBits-1] ? coord_type'(-off_x) : off_x[CoordBits-1:0];
               mag_y_in  = off_y[DeltaBits-1] ? coord_type'(-off_y) : off_y[CoordBits-1:0];
               leg_in    = (steps_ff == '0);
            end
            OP_SQX: begin
               acc_in = SqBits'(sq);
            end
            OP_SQY: begin
               acc_in = acc_ff + SqBits'(sq);
            end
            OP_SQRT_INIT: begin
               rad_in  = RadBits'(acc_ff) << FracBits;
               srem_in = '0;
               root_in = '0;
            end
            OP_SQRT_STEP: begin
               rad_in = rad_ff << 2;
               if (s_shift >= s_trial) begin
                  srem_in = (RootBits + 2)'(s_shift - s_trial);
                  root_in = {root_ff[RootBits-2:0], 1'b1};
               end else begin
                  srem_in = (RootBits + 2)'(s_shift);
                  root_in = {root_ff[RootBits-2:0], 1'b0};
               end
            end
            OP_DIV_INIT: begin
               q_in    = root_ff;
               drem_in = '0;
            end
            OP_DIV_STEP: begin
               if (d_shift >= {1'b0, speed_ff}) begin
                  drem_in = SpeedBits'(d_shift - {1'b0, speed_ff});
                  q_in    = {q_ff[RootBits-2:0], 1'b1};
               end else begin
                  drem_in = SpeedBits'(d_shift);
                  q_in    = {q_ff[RootBits-2:0], 1'b0};
               end
            end
            OP_STEPS_SET: begin
               if (steps_sum > SumBits'(StepsMax)) begin
                  steps_in = StepsBits'(StepsMax);
               end else begin
                  steps_in = StepsBits'(steps_sum);
               end
               qx_in   = mag_x_ff;
               qy_in   = mag_y_ff;
               remx_in = '0;
               remy_in = '0;
            end
            OP_DXY_STEP: begin
               if (x_shift >= {1'b0, steps_ff}) begin
                  remx_in = StepsBits'(x_shift - {1'b0, steps_ff});
                  qx_in   = {qx_ff[CoordBits-2:0], 1'b1};
               end else begin
                  remx_in = StepsBits'(x_shift);
                  qx_in   = {qx_ff[CoordBits-2:0], 1'b0};
               end
               if (y_shift >= {1'b0, steps_ff}) begin
                  remy_in = StepsBits'(y_shift - {1'b0, steps_ff});
                  qy_in   = {qy_ff[CoordBits-2:0], 1'b1};
               end else begin
                  remy_in = StepsBits'(y_shift);
                  qy_in   = {qy_ff[CoordBits-2:0], 1'b0};
               end
            end
            OP_DXY_SET: begin
               // Magnitude division, so the quotient truncates toward zero.
               dx_in = sign_x_ff ? -{1'b0, qx_ff} : {1'b0, qx_ff};
               dy_in = sign_y_ff ? -{1'b0, qy_ff} : {1'b0, qy_ff};
            end
            OP_REST: begin
               if (rest_ext == '0) begin
                  steps_in = StepsBits'(1);
               end else if (rest_ext > StepsBits'(MaxRestSteps)) begin
                  steps_in = StepsBits'(MaxRestSteps);
               end else begin
                  steps_in = rest_ext;
               end
               dx_in = '0;
               dy_in = '0;
            end
            OP_MOVE: begin
               new_x_in     = clip_x[CoordBits-1:0];
               new_y_in     = clip_y[CoordBits-1:0];
               delay_in     = leg_ff ? cfg.pause_delay : cfg.move_delay;
               leg_out_in   = leg_ff;
               rsp_valid_in = 1'b1;
               if (!leg_ff) begin
                  steps_in = steps_ff - StepsBits'(1);
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff     <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         leg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         steps_ff     <= steps_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         leg_ff       <= leg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      speed_ff   <= speed_in;
      rest_ff    <= rest_in;
      mag_x_ff   <= mag_x_in;
      mag_y_ff   <= mag_y_in;
      sign_x_ff  <= sign_x_in;
      sign_y_ff  <= sign_y_in;
      acc_ff     <= acc_in;
      rad_ff     <= rad_in;
      srem_ff    <= srem_in;
      root_ff    <= root_in;
      q_ff       <= q_in;
      drem_ff    <= drem_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      remx_ff    <= remx_in;
      remy_ff    <= remy_in;
      new_x_ff   <= new_x_in;
      new_y_ff   <= new_y_in;
      delay_ff   <= delay_in;
      leg_out_ff <= leg_out_in;
   end

endmodule

@@ design/random_waypoint_mobility_step_core.sv @@
// From input transfer to result, a movement tick runs the load, the leg test and the
// final step; a rest leg start adds the speed test and the rest setup, and a moving
// leg start adds the speed test, the two squares, the square root, the step count
// division and the delta division, all in one shared sequencer. One item at a time:
// the next item is taken the cycle after the result is written. Synchronous reset
// restores the register defaults and clears the leg state.
// ----------------------------------------------------------------------------
// random_waypoint_mobility_step_core
// Random waypoint mobility step: microcoded control over a small arithmetic
// datapath, with an APB-style register port for bounds and delays.
// ----------------------------------------------------------------------------
module random_waypoint_mobility_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rwm_pkg::coord_type req_cur_x,
   input  rwm_pkg::coord_type req_cur_y,
   input  rwm_pkg::speed_type req_rand_speed,
   input  rwm_pkg::coord_type req_rand_dest_x,
   input  rwm_pkg::coord_type req_rand_dest_y,
   input  rwm_pkg::rest_type  req_rand_rest_steps,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rwm_pkg::coord_type rsp_new_x,
   output rwm_pkg::coord_type rsp_new_y,
   output rwm_pkg::delay_type rsp_delay,
   output logic               rsp_leg_start,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  rwm_pkg::addr_type  paddr,
   input  rwm_pkg::data_type  pwdata,
   output rwm_pkg::data_type  prdata,
   output logic               pready
);
   import rwm_pkg::*;

   cfg_type  cfg;
   ctl_type  ctl;
   stat_type stat;

   rwm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rwm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   rwm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .cfg                 (cfg),
      .req_cur_x           (req_cur_x),
      .req_cur_y           (req_cur_y),
      .req_rand_speed      (req_rand_speed),
      .req_rand_dest_x     (req_rand_dest_x),
      .req_rand_dest_y     (req_rand_dest_y),
      .req_rand_rest_steps (req_rand_rest_steps),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_new_x           (rsp_new_x),
      .rsp_new_y           (rsp_new_y),
      .rsp_delay           (rsp_delay),
      .rsp_leg_start       (rsp_leg_start)
   );

endmodule
